[hw/rtl/ihp_pkg.sv]
// ----------------------------------------------------------------------------
// Indexed min-heap package
// Widths, operation codes and status codes shared by the heap design.
// ----------------------------------------------------------------------------
package ihp_pkg;

    localparam int Capacity = 256;
    localparam int KeyBits  = 32;
    localparam int IdBits   = 8;
    localparam int CntBits  = 9;
    localparam int SlotBits = 8;

    // Operation codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_CHANGE = 2'd1;
    localparam logic [1:0] OP_DELMIN = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_PRESENT = 3'd2;
    localparam logic [2:0] ST_RANGE   = 3'd3;
    localparam logic [2:0] ST_ABSENT  = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;

    // One heap entry: id and key.
    typedef struct packed {
        logic [IdBits-1:0]  id;
        logic [KeyBits-1:0] key;
    } t_entry;

endpackage

[hw/rtl/indexed_min_heap.sv]
// ----------------------------------------------------------------------------
// Indexed min-heap
// Errors and clear pass straight to the root read and the output; insert, change
// key and delete minimum first sift the entry up or down the tree level by level.
// One item at a time: start is taken only while idle, and busy is high until the result is out.
// Results appear for one cycle on o_valid; the receiver cannot stall.
// Synchronous active-low reset empties the heap and sets the limit to 256.
// ----------------------------------------------------------------------------
module indexed_min_heap (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_cfg_we,
    input  logic [ihp_pkg::CntBits-1:0] i_cfg_data,
    input  logic [1:0]                  i_operation,
    input  logic [ihp_pkg::KeyBits-1:0] i_key,
    input  logic [ihp_pkg::IdBits-1:0]  i_value,
    output logic                        o_valid,
    output logic [2:0]                  o_status,
    output logic [ihp_pkg::IdBits-1:0]  o_min_value,
    output logic [ihp_pkg::KeyBits-1:0] o_min_key,
    output logic [ihp_pkg::CntBits-1:0] o_heap_count,
    output logic                        o_is_empty
);
    import ihp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHG1, S_CHG2, S_DEL, S_UP, S_UP_CMP, S_DN, S_DN_CMP,
        S_FIN, S_ROOT, S_OUT
    } t_state;

    t_state                r_state;
    logic [CntBits-1:0]    r_limit;
    logic [CntBits-1:0]    r_cnt;
    logic [Capacity-1:0]   r_present;
    logic [SlotBits-1:0]   r_cur;
    t_entry                r_ent;
    logic [2:0]            r_status;

    // Heap memory with two registered read ports, and the id-to-slot memory.
    t_entry                m_heap [Capacity];
    logic [SlotBits-1:0]   m_slot [Capacity];
    t_entry                r_rda, r_rdb;
    logic [SlotBits-1:0]   r_rds;

    logic                  heap_we, slot_we;
    logic [SlotBits-1:0]   heap_wa, rda_a, rdb_a, slot_wa, slot_wd, slot_ra;
    t_entry                heap_wd;

    logic [CntBits-1:0]    lim;
    logic [CntBits-1:0]    lc, rc;
    logic [SlotBits-1:0]   par;
    logic                  use_r;
    t_entry                child;

    // Effective limit: zero acts as one, larger values clamp to the capacity.
    always_comb begin
        if (r_limit == '0) begin
            lim = CntBits'(1);
        end else if (r_limit > CntBits'(Capacity)) begin
            lim = CntBits'(Capacity);
        end else begin
            lim = r_limit;
        end
    end

    // Tree neighbours of the current slot.
    assign lc    = {r_cur, 1'b1};
    assign rc    = {r_cur, 1'b0} + CntBits'(2);
    assign par   = SlotBits'((r_cur - SlotBits'(1)) >> 1);
    assign use_r = (rc < r_cnt) && !($signed(r_rda.key) < $signed(r_rdb.key));
    assign child = use_r ? r_rdb : r_rda;

    // Memory port control.
    always_comb begin
        heap_we = 1'b0;
        heap_wa = r_cur;
        heap_wd = r_ent;
        slot_we = 1'b0;
        slot_wa = r_ent.id;
        slot_wd = r_cur;
        slot_ra = i_value;
        rda_a   = '0;
        rdb_a   = '0;
        unique case (r_state)
            S_IDLE: begin
                rdb_a = SlotBits'(r_cnt - CntBits'(1));
            end
            S_CHG1: begin
                rda_a = r_rds;
            end
            S_UP: begin
                rda_a = par;
            end
            S_UP_CMP: begin
                if ($signed(r_ent.key) < $signed(r_rda.key)) begin
                    heap_we = 1'b1;
                    heap_wd = r_rda;
                    slot_we = 1'b1;
                    slot_wa = r_rda.id;
                end
            end
            S_DN: begin
                rda_a = SlotBits'(lc);
                rdb_a = SlotBits'(rc);
            end
            S_DN_CMP: begin
                if ($signed(r_ent.key) > $signed(child.key)) begin
                    heap_we = 1'b1;
                    heap_wd = child;
                    slot_we = 1'b1;
                    slot_wa = child.id;
                end
            end
            S_FIN: begin
                heap_we = 1'b1;
                slot_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Memories.
    always_ff @(posedge i_clk) begin
        if (heap_we) begin
            m_heap[heap_wa] <= heap_wd;
        end
        if (slot_we) begin
            m_slot[slot_wa] <= slot_wd;
        end
        r_rda <= m_heap[rda_a];
        r_rdb <= m_heap[rdb_a];
        r_rds <= m_slot[slot_ra];
    end

    // Sequencer and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_limit      <= CntBits'(Capacity);
            r_cnt        <= '0;
            r_present    <= '0;
            o_valid      <= 1'b0;
            o_status     <= ST_OK;
            o_min_value  <= '0;
            o_min_key    <= '0;
            o_heap_count <= '0;
            o_is_empty   <= 1'b1;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_status <= ST_OK;
                        r_ent    <= '{id: i_value, key: i_key};
                        r_state  <= S_ROOT;
                        unique case (i_operation)
                            OP_INSERT: begin
                                if (r_cnt >= lim) begin
                                    r_status <= ST_FULL;
                                end else if ({1'b0, i_value} >= lim) begin
                                    r_status <= ST_RANGE;
                                end else if (r_present[i_value]) begin
                                    r_status <= ST_PRESENT;
                                end else begin
                                    r_present[i_value] <= 1'b1;
                                    r_cur   <= SlotBits'(r_cnt);
                                    r_cnt   <= r_cnt + CntBits'(1);
                                    r_state <= S_UP;
                                end
                            end
                            OP_CHANGE: begin
                                if ({1'b0, i_value} >= lim) begin
                                    r_status <= ST_RANGE;
                                end else if (!r_present[i_value]) begin
                                    r_status <= ST_ABSENT;
                                end else begin
                                    r_state <= S_CHG1;
                                end
                            end
                            OP_DELMIN: begin
                                if (r_cnt == '0) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_state <= S_DEL;
                                end
                            end
                            OP_CLEAR: begin
                                r_present <= '0;
                                r_cnt     <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_CHG1: begin
                    r_cur   <= r_rds;
                    r_state <= S_CHG2;
                end
                S_CHG2: begin
                    // A larger key sinks; an equal or smaller one rises.
                    if ($signed(r_rda.key) < $signed(r_ent.key)) begin
                        r_state <= S_DN;
                    end else begin
                        r_state <= S_UP;
                    end
                end
                S_DEL: begin
                    // The last entry replaces the root and sinks.
                    r_present[r_rda.id] <= 1'b0;
                    r_ent   <= r_rdb;
                    r_cur   <= '0;
                    r_cnt   <= r_cnt - CntBits'(1);
                    r_state <= S_DN;
                end
                S_UP: begin
                    if (r_cur == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_UP_CMP;
                    end
                end
                S_UP_CMP: begin
                    if ($signed(r_ent.key) < $signed(r_rda.key)) begin
                        r_cur   <= par;
                        r_state <= S_UP;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_DN: begin
                    if (lc >= r_cnt) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_DN_CMP;
                    end
                end
                S_DN_CMP: begin
                    if ($signed(r_ent.key) > $signed(child.key)) begin
                        r_cur   <= use_r ? SlotBits'(rc) : SlotBits'(lc);
                        r_state <= S_DN;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    o_valid      <= 1'b1;
                    o_status     <= r_status;
                    o_heap_count <= r_cnt;
                    o_is_empty   <= (r_cnt == '0);
                    o_min_value  <= (r_cnt == '0) ? '0 : r_rda.id;
                    o_min_key    <= (r_cnt == '0) ? '0 : r_rda.key;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Indexed min-heap testbench
// Drives insert, change key, delete minimum and clear items into the heap,
// predicts each result with a behavioural heap of its own and compares every
// result field by field. The capacity limit is swept through its extremes.
// ----------------------------------------------------------------------------
module tb_top;
    import ihp_pkg::*;

    typedef struct {
        logic [2:0]         status;
        logic [IdBits-1:0]  min_value;
        logic [KeyBits-1:0] min_key;
        logic [CntBits-1:0] count;
        logic               empty;
    } t_heap_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_cfg_we = 1'b0;
    logic [CntBits-1:0]   i_cfg_data = '0;
    logic [1:0]           i_operation = OP_INSERT;
    logic [KeyBits-1:0]   i_key = '0;
    logic [IdBits-1:0]    i_value = '0;
    logic                 o_valid;
    logic [2:0]           o_status;
    logic [IdBits-1:0]    o_min_value;
    logic [KeyBits-1:0]   o_min_key;
    logic [CntBits-1:0]   o_heap_count;
    logic                 o_is_empty;

    indexed_min_heap uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_operation  (i_operation),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_min_value  (o_min_value),
        .o_min_key    (o_min_key),
        .o_heap_count (o_heap_count),
        .o_is_empty   (o_is_empty)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Behavioural heap state.
    logic signed [KeyBits-1:0] hp_key [Capacity];
    logic [IdBits-1:0]         hp_id [Capacity];
    int                        hp_slot [Capacity];
    bit                        hp_held [Capacity];
    int                        hp_count;
    logic [CntBits-1:0]        cap_reg;

    t_heap_result pending_results[$];
    int           mismatches;
    int           items_sent;
    int           results_seen;
    int           status_seen [8];
    int           idle_pct;

    function automatic int limit_now();
        if (cap_reg == 0) return 1;
        if (cap_reg > Capacity) return Capacity;
        return int'(cap_reg);
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [IdBits-1:0]         ia;
        logic signed [KeyBits-1:0] k;
        ia = hp_id[a];
        k  = hp_key[a];
        hp_slot[ia]       = b;
        hp_slot[hp_id[b]] = a;
        hp_id[a]  = hp_id[b];
        hp_id[b]  = ia;
        hp_key[a] = hp_key[b];
        hp_key[b] = k;
    endfunction

    function automatic void sift_up(int s);
        while (s != 0 && hp_key[s] < hp_key[(s - 1) / 2]) begin
            swap_slots(s, (s - 1) / 2);
            s = (s - 1) / 2;
        end
    endfunction

    function automatic void sift_down(int s);
        int l;
        int m;
        forever begin
            l = 2 * s + 1;
            if (l >= hp_count) return;
            m = l;
            // On equal children the right one wins.
            if (l + 1 < hp_count && !(hp_key[l] < hp_key[l + 1])) m = l + 1;
            if (hp_key[s] > hp_key[m]) begin
                swap_slots(s, m);
                s = m;
            end else begin
                return;
            end
        end
    endfunction

    // Apply one item to the behavioural heap and return the expected result.
    function automatic t_heap_result heap_apply(logic [1:0] op,
                                                logic signed [KeyBits-1:0] k,
                                                logic [IdBits-1:0] id);
        t_heap_result r;
        int lim;
        int s;
        logic signed [KeyBits-1:0] old;
        lim = limit_now();
        r.status = ST_OK;
        case (op)
            OP_INSERT: begin
                if (hp_count >= lim) r.status = ST_FULL;
                else if (id >= lim) r.status = ST_RANGE;
                else if (hp_held[id]) r.status = ST_PRESENT;
                else begin
                    s = hp_count;
                    hp_key[s] = k;
                    hp_id[s] = id;
                    hp_slot[id] = s;
                    hp_held[id] = 1'b1;
                    hp_count++;
                    sift_up(s);
                end
            end
            OP_CHANGE: begin
                if (id >= lim) r.status = ST_RANGE;
                else if (!hp_held[id]) r.status = ST_ABSENT;
                else begin
                    s = hp_slot[id];
                    old = hp_key[s];
                    hp_key[s] = k;
                    if (old < k) sift_down(s);
                    else sift_up(s);
                end
            end
            OP_DELMIN: begin
                if (hp_count == 0) r.status = ST_EMPTY;
                else begin
                    id = hp_id[0];
                    swap_slots(0, hp_count - 1);
                    hp_count--;
                    sift_down(0);
                    hp_held[id] = 1'b0;
                end
            end
            default: begin
                foreach (hp_held[i]) hp_held[i] = 1'b0;
                hp_count = 0;
            end
        endcase
        r.count = CntBits'(hp_count);
        r.empty = (hp_count == 0);
        r.min_value = r.empty ? '0 : hp_id[0];
        r.min_key   = r.empty ? '0 : hp_key[0];
        return r;
    endfunction

    // Send one item; start stays high so that a following item can go back to back.
    task automatic send_item(logic [1:0] op, logic [KeyBits-1:0] k, logic [IdBits-1:0] id);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_key       <= k;
        i_value     <= id;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(heap_apply(op, k, id));
        items_sent++;
    endtask

    // Let every outstanding result arrive, then allow the block to settle.
    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [CntBits-1:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cap_reg = v;
    endtask

    // Result checker: every strobe must match the oldest expectation.
    always @(posedge i_clk) begin
        t_heap_result e;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result, status %0d", o_status);
            end else begin
                e = pending_results.pop_front();
                status_seen[e.status]++;
                if (o_status !== e.status || o_min_value !== e.min_value ||
                    o_min_key !== e.min_key || o_heap_count !== e.count ||
                    o_is_empty !== e.empty) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: expected st %0d id %0d key %0d cnt %0d ",
                                  "emp %0b, got st %0d id %0d key %0d cnt %0d emp %0b"},
                                 e.status, e.min_value, $signed(e.min_key), e.count, e.empty,
                                 o_status, o_min_value, $signed(o_min_key), o_heap_count,
                                 o_is_empty);
                end
            end
        end
    end

    // Directed cases: errors, extreme keys and ids, equal keys, every operation.
    task automatic test_directed();
        send_item(OP_DELMIN, 0, 8'd0);
        send_item(OP_CHANGE, 5, 8'd3);
        send_item(OP_INSERT, 32'h7FFF_FFFF, 8'd255);
        send_item(OP_INSERT, 32'h8000_0000, 8'd0);
        send_item(OP_INSERT, 7, 8'd0);
        send_item(OP_INSERT, 7, 8'd10);
        send_item(OP_INSERT, 7, 8'd11);
        send_item(OP_INSERT, 7, 8'd12);
        send_item(OP_CHANGE, 7, 8'd11);
        send_item(OP_CHANGE, 32'h7FFF_FFFF, 8'd0);
        send_item(OP_CHANGE, 32'h8000_0000, 8'd12);
        send_item(OP_CHANGE, -3, 8'd255);
        send_item(OP_DELMIN, 0, 8'd0);
        send_item(OP_DELMIN, 0, 8'd0);
        send_item(OP_CLEAR, 0, 8'd0);
        send_item(OP_DELMIN, 0, 8'd0);
        send_item(OP_INSERT, 1, 8'd200);
        send_item(OP_DELMIN, 0, 8'd0);
    endtask

    // Limit extremes: zero acts as one, over-range clamps, lowering below the count.
    task automatic test_limits();
        write_limit(9'd0);
        send_item(OP_INSERT, 4, 8'd1);
        send_item(OP_INSERT, 4, 8'd0);
        send_item(OP_INSERT, 4, 8'd0);
        send_item(OP_CHANGE, 9, 8'd1);
        write_limit(9'd511);
        send_item(OP_INSERT, 2, 8'd255);
        send_item(OP_INSERT, 3, 8'd100);
        write_limit(9'd2);
        send_item(OP_INSERT, 1, 8'd1);
        send_item(OP_CHANGE, 1, 8'd255);
        send_item(OP_DELMIN, 0, 8'd0);
        send_item(OP_DELMIN, 0, 8'd0);
        send_item(OP_INSERT, 1, 8'd1);
        send_item(OP_CLEAR, 0, 8'd0);
    endtask

    function automatic logic [KeyBits-1:0] pick_key();
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(8) - 4;
        endcase
    endfunction

    // Random items, mostly valid inserts and re-keys with some noise.
    task automatic test_random(int n, int lim_set, int pct);
        int lim;
        int pick;
        idle_pct = 0;
        write_limit(lim_set[CntBits-1:0]);
        idle_pct = pct;
        lim = limit_now();
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 3)
                send_item(OP_CLEAR, $urandom(), IdBits'($urandom()));
            else if (pick < 28)
                send_item(OP_DELMIN, $urandom(), IdBits'($urandom()));
            else if (pick < 45)
                send_item(OP_CHANGE, pick_key(),
                          IdBits'($urandom_range(9) == 0 ? $urandom_range(255)
                                                         : $urandom_range(lim - 1)));
            else
                send_item(OP_INSERT, pick_key(),
                          IdBits'($urandom_range(9) == 0 ? $urandom_range(255)
                                                         : $urandom_range(lim - 1)));
            if ($urandom_range(199) == 0) drain();
        end
    endtask

    initial begin
        hp_count = 0;
        cap_reg = 9'd256;
        foreach (hp_held[i]) hp_held[i] = 1'b0;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        idle_pct = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_limits();
        test_random(110, 256, 0);
        test_random(110, 16, 80);
        test_random(110, 1, 0);
        test_random(110, 200, 29);
        drain();

        $display("Covered %0d items, %0d results; ok %0d full %0d present %0d",
                 items_sent, results_seen, status_seen[ST_OK], status_seen[ST_FULL],
                 status_seen[ST_PRESENT]);
        $display("range errors %0d, absent %0d, empty %0d, limits 0 to 511 swept",
                 status_seen[ST_RANGE], status_seen[ST_ABSENT], status_seen[ST_EMPTY]);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
